// ===== hw/rtl/fmrc_pkg.sv =====
package fmrc_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [10:0] NIGHT_END_MIN   = 11'd360;
    localparam logic [10:0] NIGHT_START_MIN = 11'd1080;

    // care mask bit positions
    localparam int C_FLOOR   = 0;
    localparam int C_DUNGEON = 1;
    localparam int C_TOWN    = 2;
    localparam int C_DMIN    = 3;
    localparam int C_DMAX    = 4;
    localparam int C_WILD    = 5;
    localparam int C_NIGHT   = 6;
    localparam int C_GROUND  = 7;
    localparam int C_BAND    = 8;

    typedef struct packed {
        logic [1:0]         op;
        logic [8:0]         care_mask;
        logic [7:0]         floor_code;
        logic [7:0]         dungeon_num;
        logic [7:0]         town_id;
        logic [7:0]         depth_low;
        logic [7:0]         depth_high;
        logic [1:0]         flags;
        logic [3:0]         ground_kind;
        logic [1:0]         daypart;
        logic signed [11:0] clock_min;
        logic [7:0]         sound_id;
    } t_req;

    typedef struct packed {
        logic       hit;
        logic [7:0] sound_out;
        logic [3:0] rule_index;
        logic [4:0] rule_count_out;
        logic       table_full;
    } t_rsp;

    // scene broadcast to every cell during a lookup walk
    typedef struct packed {
        logic [7:0] floor_code;
        logic [7:0] dungeon_num;
        logic [7:0] town_id;
        logic [7:0] depth;
        logic       wild;
        logic       night;
        logic [3:0] ground_kind;
        logic [1:0] daypart;
    } t_scene;

    // rule write, broadcast with a target slot
    typedef struct packed {
        logic       en;
        logic [7:0] slot;
        t_req       rule;
    } t_wr;

    // lookup token handed from cell to cell
    typedef struct packed {
        logic       valid;
        logic       found;
        logic [7:0] sound;
        logic [3:0] idx;
    } t_tok;

endpackage

// ===== hw/rtl/fmrc_rule_cell.sv =====
module fmrc_rule_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fmrc_pkg::t_wr    i_wr,
    input  fmrc_pkg::t_scene i_scene,
    input  logic [CW-1:0]   i_count,
    input  fmrc_pkg::t_tok   i_tok,
    output fmrc_pkg::t_tok   o_tok
);
    import fmrc_pkg::*;

    logic [8:0] r_care;
    logic [7:0] r_floor;
    logic [7:0] r_dungeon;
    logic [7:0] r_town;
    logic [7:0] r_dmin;
    logic [7:0] r_dmax;
    logic       r_wild;
    logic       r_night;
    logic [3:0] r_ground;
    logic [1:0] r_band;
    logic [7:0] r_sound;
    t_tok       r_tok;
    t_tok       n_tok;
    logic       w_active;
    logic       w_match;

    assign w_active = CW'(IDX) < i_count;

    always_comb begin
        w_match = 1'b1;
        if (r_care[C_FLOOR]   && r_floor   != i_scene.floor_code)  w_match = 1'b0;
        if (r_care[C_DUNGEON] && r_dungeon != i_scene.dungeon_num) w_match = 1'b0;
        if (r_care[C_TOWN]    && r_town    != i_scene.town_id)     w_match = 1'b0;
        if (r_care[C_DMIN]    && i_scene.depth < r_dmin)           w_match = 1'b0;
        if (r_care[C_DMAX]    && i_scene.depth > r_dmax)           w_match = 1'b0;
        if (r_care[C_WILD]    && r_wild    != i_scene.wild)        w_match = 1'b0;
        if (r_care[C_NIGHT]   && r_night   != i_scene.night)       w_match = 1'b0;
        if (r_care[C_GROUND]  && r_ground  != i_scene.ground_kind) w_match = 1'b0;
        if (r_care[C_BAND]    && r_band    != i_scene.daypart)     w_match = 1'b0;
    end

    always_comb begin
        n_tok = i_tok;
        // first active match claims the token; later cells pass it on
        if (i_tok.valid && !i_tok.found && w_active && w_match) begin
            n_tok.found = 1'b1;
            n_tok.sound = r_sound;
            n_tok.idx   = 4'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.found <= n_tok.found;
        r_tok.sound <= n_tok.sound;
        r_tok.idx   <= n_tok.idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.slot == 8'(IDX)) begin
            r_care    <= i_wr.rule.care_mask;
            r_floor   <= i_wr.rule.floor_code;
            r_dungeon <= i_wr.rule.dungeon_num;
            r_town    <= i_wr.rule.town_id;
            r_dmin    <= i_wr.rule.depth_low;
            r_dmax    <= i_wr.rule.depth_high;
            r_wild    <= i_wr.rule.flags[0];
            r_night   <= i_wr.rule.flags[1];
            r_ground  <= i_wr.rule.ground_kind;
            r_band    <= i_wr.rule.daypart;
            r_sound   <= i_wr.rule.sound_id;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hw/rtl/first_match_rule_classifier_core.sv =====
// Clear, append, unused op codes and a lookup on an empty table: the result is
// registered in S_POST, which waits for the output register to be free.
// Lookup on a non-empty table: S_WALK, then S_POST; in S_WALK
// the token walks the rule cells one per cycle.
// A new request is taken only when the previous one has reached the output register.
// Reset empties the table (rule count 0); rule contents stay undefined until written.
module first_match_rule_classifier_core #(
    parameter int MAX_RULES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fmrc_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output fmrc_pkg::t_rsp o_rsp
);
    import fmrc_pkg::*;

    localparam int CW = $clog2(MAX_RULES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_POST
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_launch;
    logic          n_launch;
    t_scene        r_scene;
    t_scene        n_scene;
    t_rsp          r_res;
    t_rsp          n_res;
    t_rsp          r_out;
    logic          r_out_valid;
    logic          w_accept;
    logic          w_full;
    t_wr           w_wr;
    t_tok          w_tok [MAX_RULES+1];

    assign o_ready  = r_state == S_IDLE;
    assign w_accept = i_valid && o_ready;
    assign w_full   = r_count == CW'(MAX_RULES);
    assign n_launch = w_accept && i_req.op == OP_LOOKUP && r_count != '0;

    always_comb begin
        n_scene.floor_code  = i_req.floor_code;
        n_scene.dungeon_num = i_req.dungeon_num;
        n_scene.town_id     = i_req.town_id;
        n_scene.depth       = i_req.depth_low;
        n_scene.wild        = i_req.flags[0];
        // negative minute means unknown, never night
        n_scene.night       = !i_req.clock_min[11] &&
                              (i_req.clock_min[10:0] < NIGHT_END_MIN ||
                               i_req.clock_min[10:0] >= NIGHT_START_MIN);
        n_scene.ground_kind = i_req.ground_kind;
        n_scene.daypart     = i_req.daypart;
    end

    always_comb begin
        n_count          = r_count;
        n_res.hit        = 1'b0;
        n_res.sound_out  = 8'd0;
        n_res.rule_index = 4'd0;
        n_res.table_full = 1'b0;
        case (i_req.op)
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_APPEND: begin
                if (w_full) begin
                    n_res.table_full = 1'b1;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_res.rule_count_out = 5'(n_count);
    end

    always_comb begin
        w_wr.en   = w_accept && i_req.op == OP_APPEND && !w_full;
        w_wr.slot = 8'(r_count);
        w_wr.rule = i_req;
    end

    assign w_tok[0].valid = r_launch;
    assign w_tok[0].found = 1'b0;
    assign w_tok[0].sound = 8'd0;
    assign w_tok[0].idx   = 4'd0;

    for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
        fmrc_rule_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr),
            .i_scene (r_scene),
            .i_count (r_count),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= n_launch;
            if (r_out_valid && i_ready && r_state != S_POST) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count <= n_count;
                        r_scene <= n_scene;
                        r_res   <= n_res;
                        if (n_launch) begin
                            r_state <= S_WALK;
                        end else begin
                            r_state <= S_POST;
                        end
                    end
                end
                S_WALK: begin
                    if (w_tok[MAX_RULES].valid) begin
                        r_res.hit <= w_tok[MAX_RULES].found;
                        if (w_tok[MAX_RULES].found) begin
                            r_res.sound_out  <= w_tok[MAX_RULES].sound;
                            r_res.rule_index <= w_tok[MAX_RULES].idx;
                        end
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import fmrc_pkg::*;

    localparam int MAX_RULES       = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_LIMIT     = 50000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_req i_req;
    logic o_valid;
    logic i_ready;
    t_rsp o_rsp;

    first_match_rule_classifier_core #(
        .MAX_RULES(MAX_RULES)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_rsp  (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state: the rule table as this side sees it
    t_req stored_rules [MAX_RULES];
    int   stored_count;

    t_rsp pending_rsp [$];

    bit idle_enable;
    int hold_off_seq;
    int hold_off_seen;
    int hold_off_left;

    int error_count;
    int sent_total;
    int results_checked;
    int cnt_lookup;
    int cnt_hit;
    int cnt_append;
    int cnt_full;

    function automatic bit scene_is_night(input logic signed [11:0] minute);
        int m;
        int night_end;
        int night_start;
        m           = minute;
        night_end   = NIGHT_END_MIN;
        night_start = NIGHT_START_MIN;
        return (m >= 0) && (m < night_end || m >= night_start);
    endfunction

    function automatic bit rule_hits_scene(input t_req rule, input t_req scene, input bit night);
        logic [8:0] care;
        bit ok;
        care = rule.care_mask;
        ok   = 1'b1;
        if (care[C_FLOOR]   && rule.floor_code  != scene.floor_code)  ok = 1'b0;
        if (care[C_DUNGEON] && rule.dungeon_num != scene.dungeon_num) ok = 1'b0;
        if (care[C_TOWN]    && rule.town_id     != scene.town_id)     ok = 1'b0;
        if (care[C_DMIN]    && scene.depth_low  <  rule.depth_low)    ok = 1'b0;
        if (care[C_DMAX]    && scene.depth_low  >  rule.depth_high)   ok = 1'b0;
        if (care[C_WILD]    && rule.flags[0]    != scene.flags[0])    ok = 1'b0;
        if (care[C_NIGHT]   && rule.flags[1]    != night)             ok = 1'b0;
        if (care[C_GROUND]  && rule.ground_kind != scene.ground_kind) ok = 1'b0;
        if (care[C_BAND]    && rule.daypart     != scene.daypart)     ok = 1'b0;
        return ok;
    endfunction

    // apply one request to the predicted table and return the expected result
    function automatic t_rsp classify_req(input t_req r);
        t_rsp p;
        bit night;
        bit found;
        p = '0;
        case (r.op)
            OP_CLEAR: begin
                stored_count = 0;
            end
            OP_APPEND: begin
                if (stored_count >= MAX_RULES) begin
                    p.table_full = 1'b1;
                end else begin
                    stored_rules[stored_count] = r;
                    stored_count++;
                end
            end
            OP_LOOKUP: begin
                night = scene_is_night(r.clock_min);
                found = 1'b0;
                for (int i = 0; i < stored_count; i++) begin
                    if (!found && rule_hits_scene(stored_rules[i], r, night)) begin
                        found        = 1'b1;
                        p.hit        = 1'b1;
                        p.sound_out  = stored_rules[i].sound_id;
                        p.rule_index = 4'(i);
                    end
                end
            end
            default: begin
            end
        endcase
        p.rule_count_out = 5'(stored_count);
        return p;
    endfunction

    task automatic send_req(input t_req r);
        t_rsp p;
        @(negedge i_clk);
        while (idle_enable && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        p = classify_req(r);
        pending_rsp.insert(pending_rsp.size(), p);
        sent_total++;
        if (r.op == OP_LOOKUP) begin
            cnt_lookup++;
            if (p.hit) cnt_hit++;
        end
        if (r.op == OP_APPEND) cnt_append++;
        if (p.table_full) cnt_full++;
    endtask

    function automatic t_req blank_req(input logic [1:0] op);
        t_req r;
        r    = '0;
        r.op = op;
        return r;
    endfunction

    function automatic logic signed [11:0] pick_minute(input bit want_night);
        logic signed [11:0] m;
        int sel;
        sel = $urandom_range(0, 5);
        if (want_night) begin
            case (sel)
                0: m = 12'd0;
                1: m = 12'(NIGHT_END_MIN - 1);
                2: m = 12'(NIGHT_START_MIN);
                3: m = 12'd1439;
                4: m = 12'($urandom_range(1440, 2047));
                default: m = $urandom_range(0, 1) ? 12'($urandom_range(0, 359))
                                                  : 12'($urandom_range(1080, 1439));
            endcase
        end else begin
            case (sel)
                0: m = 12'(NIGHT_END_MIN);
                1: m = 12'(NIGHT_START_MIN - 1);
                2: m = 12'hFFF;
                3: m = 12'h800;
                4: m = {1'b1, 11'($urandom)};
                default: m = 12'($urandom_range(360, 1079));
            endcase
        end
        return m;
    endfunction

    function automatic t_req make_rule();
        t_req r;
        logic [7:0] tmp;
        r = blank_req(OP_APPEND);
        for (int b = 0; b < 9; b++) r.care_mask[b] = ($urandom_range(0, 99) < 30);
        if ($urandom_range(0, 3) == 0) r.care_mask = 9'($urandom);
        r.floor_code  = 8'($urandom);
        r.dungeon_num = 8'($urandom);
        r.town_id     = 8'($urandom);
        r.depth_low   = 8'($urandom);
        r.depth_high  = 8'($urandom);
        // keep most depth windows open so scenes can land inside them
        if (r.depth_low > r.depth_high && $urandom_range(0, 3) != 0) begin
            tmp          = r.depth_low;
            r.depth_low  = r.depth_high;
            r.depth_high = tmp;
        end
        r.flags       = 2'($urandom);
        r.ground_kind = 4'($urandom);
        r.daypart     = 2'($urandom);
        r.clock_min   = 12'($urandom);
        r.sound_id    = 8'($urandom);
        return r;
    endfunction

    // build a scene that satisfies the rule, then sometimes spoil one criterion
    function automatic t_req make_scene_for(input t_req rule);
        t_req s;
        s = blank_req(OP_LOOKUP);
        s.care_mask   = 9'($urandom);
        s.floor_code  = rule.floor_code;
        s.dungeon_num = rule.dungeon_num;
        s.town_id     = rule.town_id;
        s.depth_low   = (rule.depth_low <= rule.depth_high)
                        ? 8'($urandom_range(rule.depth_low, rule.depth_high)) : 8'($urandom);
        s.depth_high  = 8'($urandom);
        s.flags       = {1'($urandom), rule.flags[0]};
        s.ground_kind = rule.ground_kind;
        s.daypart     = rule.daypart;
        s.clock_min   = pick_minute(rule.flags[1]);
        s.sound_id    = 8'($urandom);
        if ($urandom_range(0, 99) < 30) begin
            case ($urandom_range(0, 7))
                0: s.floor_code  = s.floor_code ^ 8'($urandom_range(1, 255));
                1: s.dungeon_num = s.dungeon_num ^ 8'($urandom_range(1, 255));
                2: s.town_id     = s.town_id ^ 8'($urandom_range(1, 255));
                3: s.depth_low   = 8'($urandom);
                4: s.flags[0]    = ~s.flags[0];
                5: s.clock_min   = pick_minute(!rule.flags[1]);
                6: s.ground_kind = s.ground_kind ^ 4'($urandom_range(1, 15));
                default: s.daypart = s.daypart ^ 2'($urandom_range(1, 3));
            endcase
        end
        return s;
    endfunction

    function automatic t_req random_item();
        logic [95:0] raw;
        t_req r;
        raw = {$urandom, $urandom, $urandom};
        r   = raw[$bits(t_req)-1:0];
        return r;
    endfunction

    function automatic t_req random_scene();
        t_req s;
        s    = random_item();
        s.op = OP_LOOKUP;
        if ($urandom_range(0, 1)) s.clock_min = pick_minute(1'($urandom));
        return s;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rsp.size() == 0) begin
                error_count++;
                $display("%0t: result with none expected, expected none, actual %p",
                         $time, o_rsp);
            end else begin
                want = pending_rsp.pop_front();
                check_field("hit",            8'(want.hit),            8'(o_rsp.hit));
                check_field("sound_out",      want.sound_out,          o_rsp.sound_out);
                check_field("rule_index",     8'(want.rule_index),     8'(o_rsp.rule_index));
                check_field("rule_count_out", 8'(want.rule_count_out), 8'(o_rsp.rule_count_out));
                check_field("table_full",     8'(want.table_full),     8'(o_rsp.table_full));
                results_checked++;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_ready <= 1'b0;
        end else if (hold_off_seq != hold_off_seen) begin
            hold_off_seen = hold_off_seq;
            hold_off_left = HOLD_OFF_CYCLES - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(idle_enable && $urandom_range(0, 99) < 10);
        end
    end

    task automatic test_op_codes();
        t_req r;
        send_req(blank_req(OP_CLEAR));
        // lookup on an empty table, every scene field at its top value
        r           = '1;
        r.op        = OP_LOOKUP;
        r.clock_min = 12'hFFF;
        send_req(r);
        r    = '1;
        r.op = OP_UNUSED;
        send_req(r);
    endtask

    task automatic test_table_full();
        t_req r;
        t_req scene;
        send_req(blank_req(OP_CLEAR));
        for (int i = 0; i < MAX_RULES; i++) begin
            r          = blank_req(OP_APPEND);
            r.sound_id = (i == 0) ? 8'hFF : 8'(i * 16 + 1);
            case (i)
                0: begin r.care_mask[C_FLOOR]   = 1'b1; r.floor_code  = 8'hFF; end
                1: begin r.care_mask[C_DUNGEON] = 1'b1; r.dungeon_num = 8'h00; end
                2: begin r.care_mask[C_TOWN]    = 1'b1; r.town_id     = 8'hFF; end
                3: begin r.care_mask[C_DMIN]    = 1'b1; r.depth_low   = 8'd200; end
                4: begin r.care_mask[C_DMAX]    = 1'b1; r.depth_high  = 8'd10; end
                5: begin r.care_mask[C_WILD]    = 1'b1; r.flags       = 2'b01; end
                6: begin r.care_mask[C_NIGHT]   = 1'b1; r.flags       = 2'b10; end
                7: begin r.care_mask[C_GROUND]  = 1'b1; r.ground_kind = 4'hF; end
                8: begin r.care_mask[C_BAND]    = 1'b1; r.daypart     = 2'd3; end
                9: begin
                    // inverted depth window never matches
                    r.care_mask[C_DMIN] = 1'b1;
                    r.care_mask[C_DMAX] = 1'b1;
                    r.depth_low         = 8'd200;
                    r.depth_high        = 8'd10;
                end
                10: begin
                    r             = '1;
                    r.op          = OP_APPEND;
                    r.depth_low   = 8'h00;
                end
                MAX_RULES - 1: begin
                    // catch-all with explicit silence
                    r.care_mask = '0;
                    r.sound_id  = 8'h00;
                end
                default: begin
                    r.care_mask[C_FLOOR] = 1'b1;
                    r.floor_code         = 8'hF0 + 8'(i);
                end
            endcase
            send_req(r);
        end
        r           = make_rule();
        r.care_mask = 9'h1FF;
        send_req(r);

        scene             = blank_req(OP_LOOKUP);
        scene.dungeon_num = 8'd1;
        scene.depth_low   = 8'd100;
        scene.clock_min   = 12'd720;
        send_req(scene);
        scene.clock_min = 12'(NIGHT_END_MIN - 1);
        send_req(scene);
        scene.clock_min = 12'(NIGHT_END_MIN);
        send_req(scene);
        scene.clock_min = 12'(NIGHT_START_MIN);
        send_req(scene);
        scene.clock_min = 12'd720;
        scene.depth_low = 8'd0;
        send_req(scene);
        scene.depth_low = 8'hFF;
        send_req(scene);
    endtask

    task automatic test_output_backpressure();
        idle_enable = 1'b0;
        hold_off_seq++;
        send_req(blank_req(OP_CLEAR));
        repeat (24) begin
            if ($urandom_range(0, 1) && stored_count > 0)
                send_req(make_scene_for(stored_rules[$urandom_range(0, stored_count - 1)]));
            else
                send_req(make_rule());
        end
    endtask

    task automatic test_random_traffic(input int n_items, input bit with_idle);
        int start;
        int n_look;
        idle_enable = with_idle;
        start       = sent_total;
        while (sent_total - start < n_items) begin
            if ($urandom_range(0, 99) < 80) begin
                if ($urandom_range(0, 99) < 70) send_req(blank_req(OP_CLEAR));
                repeat ($urandom_range(1, 18)) send_req(make_rule());
                n_look = $urandom_range(2, 10);
                repeat (n_look) begin
                    if (stored_count > 0 && $urandom_range(0, 99) < 75)
                        send_req(make_scene_for(
                            stored_rules[$urandom_range(0, stored_count - 1)]));
                    else
                        send_req(random_scene());
                end
            end else begin
                repeat ($urandom_range(1, 5)) send_req(random_item());
            end
        end
    endtask

    initial begin
        int drain_cycles;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_req        = '0;
        i_ready      = 1'b0;
        idle_enable  = 1'b0;
        stored_count = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_op_codes();
        test_table_full();
        test_output_backpressure();
        test_random_traffic(80, 1'b0);
        test_random_traffic(340, 1'b1);

        @(negedge i_clk);
        i_valid <= 1'b0;
        drain_cycles = 0;
        while (pending_rsp.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        if (pending_rsp.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, pending_rsp.size());
        end
        repeat (2 * MAX_RULES + 8) @(posedge i_clk);

        $display("Ran %0d requests: %0d appends (%0d dropped on a full table), %0d lookups",
                 sent_total, cnt_append, cnt_full, cnt_lookup);
        $display("Lookups that hit a rule: %0d; results compared: %0d; errors: %0d",
                 cnt_hit, results_checked, error_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Run timed out with %0d results outstanding", pending_rsp.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
